[rtl/qsa_pkg.sv]
// Shared types, constants and the quadrature step table for the speed averager.
package qsa_pkg;

  localparam int SCALE_W      = 24;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd507355;
  localparam int AVG_DEPTH_DEF = 10;
  localparam int POS_W        = 32;
  localparam int DELTA_W      = 16;
  localparam int PROD_W       = DELTA_W + SCALE_W + 1;
  localparam int FRAC_DROP    = 8;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 72;

  localparam int IN_A_BIT     = 0;
  localparam int IN_B_BIT     = 1;
  localparam int IN_TICK_BIT  = 2;
  localparam int IN_CLEAR_BIT = 3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_RND,
    ST_RING,
    ST_START,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    STEP_NONE,
    STEP_UP,
    STEP_DOWN
  } step_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam logic [3:0] CODE_DN0 = 4'b0001;
  localparam logic [3:0] CODE_DN1 = 4'b0111;
  localparam logic [3:0] CODE_DN2 = 4'b1110;
  localparam logic [3:0] CODE_DN3 = 4'b1000;
  localparam logic [3:0] CODE_UP0 = 4'b0010;
  localparam logic [3:0] CODE_UP1 = 4'b0100;
  localparam logic [3:0] CODE_UP2 = 4'b1011;
  localparam logic [3:0] CODE_UP3 = 4'b1101;

  function automatic step_t step_of(input logic [3:0] code);
    step_t s;
    case (code)
      CODE_DN0, CODE_DN1, CODE_DN2, CODE_DN3: s = STEP_DOWN;
      CODE_UP0, CODE_UP1, CODE_UP2, CODE_UP3: s = STEP_UP;
      default: s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

[rtl/qsa_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module qsa_div #(
  parameter int N_W = 36,
  parameter int D_W = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  qsa_pkg::div_ctl_t   ctl,
  input  logic [N_W-1:0]      dividend,
  input  logic [D_W-1:0]      divisor,
  output qsa_pkg::div_stat_t  stat,
  output logic [N_W-1:0]      quotient
);
  import qsa_pkg::*;

  localparam int CNT_W = $clog2(N_W + 1);

  logic [N_W-1:0]   quo;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [D_W:0]     trial;
  logic             fits;

  assign trial = {rem, quo[N_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[N_W-2:0], fits};
      rem <= fits ? D_W'(trial - {1'b0, dvs}) : trial[D_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

[rtl/quadrature_speed_averager_top.sv]
// Quadrature decoder with moving-average speed, top level and sequencer.
// An item without a speed tick (or with clear) goes from idle to the output state and back to idle.
// A tick item steps through diff, multiply, round, ring, divider start, bit-serial divide and fix before output.
// One item at a time; the next is accepted as soon as the result sits in the output register.
// rst (synchronous) zeroes position, history, fill state and held speed; scale returns to reset.
module quadrature_speed_averager_top #(
  parameter int AVG_DEPTH = qsa_pkg::AVG_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              scale_we,
  input  logic [qsa_pkg::SCALE_W-1:0]       scale_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // enc_a, enc_b, speed_tick, clear, zero pad
  input  logic [qsa_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // position[31:0], avg_speed[63:32], speed_valid[64], zero pad
  output logic [qsa_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import qsa_pkg::*;

  localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int CNT_W  = $clog2(AVG_DEPTH + 1);
  localparam int SUM_W  = POS_W + $clog2(AVG_DEPTH);
  localparam int PAD_W  = OUT_TDATA_W - 2 * POS_W - 1;

  state_t state, state_next;

  logic [SCALE_W-1:0]       scale;
  logic [1:0]               last_ab;
  logic                     primed;
  logic [POS_W-1:0]         count_pos;
  logic [POS_W-1:0]         count_at_tick;
  logic signed [POS_W-1:0]  speed_ring [AVG_DEPTH];
  logic [SLOT_W-1:0]        write_slot;
  logic                     ring_full;
  logic signed [SUM_W-1:0]  ring_sum;
  logic signed [POS_W-1:0]  speed_hold;
  logic                     valid_pend;
  logic signed [DELTA_W-1:0] delta;
  logic signed [PROD_W-1:0] prod;
  logic signed [POS_W-1:0]  inst;
  logic [CNT_W-1:0]         cnt;
  logic                     sum_neg;

  logic                     in_accept;
  logic                     in_clear;
  logic                     in_tick;
  logic [1:0]               in_ab;
  step_t                    step;
  logic [POS_W-1:0]         diff;
  logic                     diff_fits;
  logic [PROD_W-1:0]        rnd;
  logic [SLOT_W-1:0]        slot_next;
  logic                     slot_wrap;
  logic [SUM_W-1:0]         sum_mag;
  logic [SUM_W-1:0]         quotient;
  logic [SUM_W-1:0]         q_fix;
  logic                     out_load;
  div_ctl_t                 div_ctl;
  div_stat_t                div_stat;

  assign in_accept = s_tvalid && s_tready;
  assign in_clear  = s_tdata[IN_CLEAR_BIT];
  assign in_tick   = s_tdata[IN_TICK_BIT];
  assign in_ab     = {s_tdata[IN_A_BIT], s_tdata[IN_B_BIT]};
  assign step      = step_of({last_ab, in_ab});

  assign diff      = count_pos - count_at_tick;
  assign diff_fits = (diff[POS_W-1:DELTA_W-1] == '0) || (diff[POS_W-1:DELTA_W-1] == '1);
  assign rnd       = prod + PROD_W'({FRAC_DROP{prod[PROD_W-1]}});
  assign slot_wrap = (write_slot == SLOT_W'(AVG_DEPTH - 1));
  assign slot_next = slot_wrap ? '0 : write_slot + 1'b1;
  assign sum_mag   = ring_sum[SUM_W-1] ? SUM_W'(-ring_sum) : SUM_W'(ring_sum);
  assign q_fix     = sum_neg ? (~quotient + 1'b1) : quotient;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_tvalid) begin
                  state_next = (in_clear || !in_tick) ? ST_OUT : ST_DIFF;
                end
      ST_DIFF:  state_next = ST_MUL;
      ST_MUL:   state_next = ST_RND;
      ST_RND:   state_next = ST_RING;
      ST_RING:  state_next = ST_START;
      ST_START: state_next = ST_DIV;
      ST_DIV:   if (div_stat.done) begin
                  state_next = ST_FIX;
                end
      ST_FIX:   state_next = ST_OUT;
      ST_OUT:   if (!m_tvalid || m_tready) begin
                  state_next = ST_IDLE;
                end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = 1'b0;
    div_ctl.start = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_START: div_ctl.start = 1'b1;
      ST_OUT:   out_load = !m_tvalid || m_tready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (scale_we) begin
      scale <= scale_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_ab       <= '0;
      primed        <= 1'b0;
      count_pos     <= '0;
      count_at_tick <= '0;
      write_slot    <= '0;
      ring_full     <= 1'b0;
      ring_sum      <= '0;
      speed_hold    <= '0;
      valid_pend    <= 1'b0;
      cnt           <= CNT_W'(1);
      for (int i = 0; i < AVG_DEPTH; i++) begin
        speed_ring[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: if (in_accept) begin
          last_ab    <= in_ab;
          primed     <= 1'b1;
          valid_pend <= !in_clear && in_tick;
          if (in_clear) begin
            count_pos     <= '0;
            count_at_tick <= '0;
            write_slot    <= '0;
            ring_full     <= 1'b0;
            ring_sum      <= '0;
            for (int i = 0; i < AVG_DEPTH; i++) begin
              speed_ring[i] <= '0;
            end
          end else if (primed && step == STEP_UP) begin
            count_pos <= count_pos + 1'b1;
          end else if (primed && step == STEP_DOWN) begin
            count_pos <= count_pos - 1'b1;
          end
        end
        ST_DIFF: begin
          count_at_tick <= count_pos;
          if (diff_fits) begin
            delta <= diff[DELTA_W-1:0];
          end else begin
            delta <= diff[POS_W-1] ? {1'b1, {(DELTA_W-1){1'b0}}} : {1'b0, {(DELTA_W-1){1'b1}}};
          end
        end
        ST_MUL: prod <= delta * $signed({1'b0, scale});
        ST_RND: inst <= rnd[POS_W+FRAC_DROP-1:FRAC_DROP];
        ST_RING: begin
          speed_ring[write_slot] <= inst;
          ring_sum   <= ring_sum + SUM_W'(inst) - SUM_W'(speed_ring[write_slot]);
          write_slot <= slot_next;
          if (slot_wrap) begin
            ring_full <= 1'b1;
          end
          cnt <= (ring_full || slot_wrap) ? CNT_W'(AVG_DEPTH) : CNT_W'(slot_next);
        end
        ST_START: sum_neg <= ring_sum[SUM_W-1];
        ST_FIX:   speed_hold <= q_fix[POS_W-1:0];
        default:  ;
      endcase
    end
  end

  qsa_div #(
    .N_W (SUM_W),
    .D_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (sum_mag),
    .divisor  (cnt),
    .stat     (div_stat),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{PAD_W{1'b0}}, valid_pend, speed_hold, count_pos};
    end
  end

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    write_slot < AVG_DEPTH)
    else $error("write slot out of range");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_clear |=> ring_sum == '0 && !ring_full && count_pos == '0)
    else $error("clear request left history behind");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && valid_pend |-> ring_full || write_slot != '0)
    else $error("new average with an empty ring");

endmodule
